// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file rsi_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, quiet while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also covers reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/rsi_pkg.sv
`default_nettype none
package rsi_pkg;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_in_t;

    typedef struct packed {
        logic               hit;
        logic        [30:0] hit_distance;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } hit_out_t;

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_TOLERANCE = 3'd4
    } cfg_reg_t;

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;
    localparam logic signed [31:0] INT32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN   = 32'sh8000_0000;

    localparam int SQ_STAGES = 16;
    localparam int DV_STAGES = 16;

    // per-axis ray context, index 0 is x
    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
        logic [2:0][32:0] c;
    } ray_ctx_t;

    typedef struct packed {
        ray_ctx_t    ctx;
        logic [34:0] tca;
        logic        onsurf;
        logic        cand;
    } sq_side_t;

    typedef struct packed {
        logic             ok;
        logic [30:0]      tlen;
        logic [2:0][31:0] p;
        logic [2:0]       neg;
        logic [2:0]       ovf;
    } dv_side_t;

endpackage
`default_nettype wire

// File: hw/rtl/rsi_isqrt.sv
`default_nettype none
module rsi_isqrt import rsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_rad,
    input  sq_side_t    in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output sq_side_t    out_side
);

    logic [SQ_STAGES-1:0] vld_reg;
    logic [63:0] rad_reg  [SQ_STAGES];
    logic [33:0] rem_reg  [SQ_STAGES];
    logic [31:0] root_reg [SQ_STAGES];
    sq_side_t    side_reg [SQ_STAGES];

    logic [63:0] rad_next  [SQ_STAGES];
    logic [33:0] rem_next  [SQ_STAGES];
    logic [31:0] root_next [SQ_STAGES];

    // one digit pair of the restoring root
    function automatic logic [65:0] sq_step(input logic [33:0] rem, input logic [31:0] root,
                                            input logic [1:0] pair);
        logic [35:0] acc;
        logic [35:0] trial;
        acc   = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (acc >= trial) begin
            return {34'(acc - trial), root[30:0], 1'b1};
        end else begin
            return {acc[33:0], root[30:0], 1'b0};
        end
    endfunction

    always_comb begin
        logic [63:0] ri;
        logic [33:0] re;
        logic [31:0] ro;
        logic [65:0] mid;
        logic [65:0] fin;
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (s == 0) begin
                ri = in_rad;
                re = '0;
                ro = '0;
            end else begin
                ri = rad_reg[s-1];
                re = rem_reg[s-1];
                ro = root_reg[s-1];
            end
            mid          = sq_step(re, ro, ri[63:62]);
            fin          = sq_step(mid[65:32], mid[31:0], ri[61:60]);
            rad_next[s]  = {ri[59:0], 4'b0000};
            rem_next[s]  = fin[65:32];
            root_next[s] = fin[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < SQ_STAGES; s++) begin
                rad_reg[s]  <= rad_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                side_reg[s] <= (s == 0) ? in_side : side_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/rsi_div.sv
`default_nettype none
module rsi_div import rsi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [30:0]      den,
    input  logic [2:0][30:0] in_rem,
    input  logic [2:0][31:0] in_low,
    input  dv_side_t         in_side,
    output logic             out_valid,
    output logic [2:0][31:0] out_quo,
    output dv_side_t         out_side
);

    logic [DV_STAGES-1:0] vld_reg;
    logic [2:0][30:0] rem_reg [DV_STAGES];
    logic [2:0][31:0] low_reg [DV_STAGES];
    logic [2:0][31:0] quo_reg [DV_STAGES];
    dv_side_t         side_reg [DV_STAGES];

    logic [2:0][30:0] rem_next [DV_STAGES];
    logic [2:0][31:0] low_next [DV_STAGES];
    logic [2:0][31:0] quo_next [DV_STAGES];

    // one restoring step: shift in a numerator bit, subtract when it fits
    function automatic logic [62:0] dv_step(input logic [30:0] rem, input logic [31:0] quo,
                                            input logic nbit, input logic [30:0] dv);
        logic [31:0] acc;
        acc = {rem, nbit};
        if (acc >= {1'b0, dv}) begin
            return {31'(acc - {1'b0, dv}), quo[30:0], 1'b1};
        end else begin
            return {acc[30:0], quo[30:0], 1'b0};
        end
    endfunction

    always_comb begin
        logic [30:0] re;
        logic [31:0] lo;
        logic [31:0] qu;
        logic [62:0] mid;
        logic [62:0] fin;
        for (int s = 0; s < DV_STAGES; s++) begin
            for (int l = 0; l < 3; l++) begin
                if (s == 0) begin
                    re = in_rem[l];
                    lo = in_low[l];
                    qu = '0;
                end else begin
                    re = rem_reg[s-1][l];
                    lo = low_reg[s-1][l];
                    qu = quo_reg[s-1][l];
                end
                mid            = dv_step(re, qu, lo[31], den);
                fin            = dv_step(mid[62:32], mid[31:0], lo[30], den);
                rem_next[s][l] = fin[62:32];
                quo_next[s][l] = fin[31:0];
                low_next[s][l] = {lo[29:0], 2'b00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DV_STAGES; s++) begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                quo_reg[s]  <= quo_next[s];
                side_reg[s] <= (s == 0) ? in_side : side_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign out_valid = vld_reg[DV_STAGES-1];
    assign out_quo   = quo_reg[DV_STAGES-1];
    assign out_side  = side_reg[DV_STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/ray_sphere_intersect.sv
`default_nettype none
// throughput: one ray per cycle while the output is not stalled; 8 setup stages,
// 16-stage square root (2 bits per stage), 3 hit-point stages, 16-stage normal divider
// (2 quotient bits per stage), output register
// a stalled output freezes the whole pipeline, s_ready follows it
// reset: synchronous active-low aresetn clears all valid bits, centre 0, radius 1.0, eps 1
module ray_sphere_intersect import rsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ray_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hit_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic adv;

    // configuration
    logic [2:0][31:0] ctr_reg;
    logic [30:0]      radius_reg;
    logic [15:0]      tol_reg;
    logic [31:0]      up;
    logic [31:0]      lo;
    logic [63:0]      up_sq_reg;
    logic [61:0]      lo_sq_reg;
    logic             lo_neg_reg;
    logic [61:0]      rsq_reg;

    assign cfg_ready = 1'b1;
    assign up = {1'b0, radius_reg} + {16'b0, tol_reg};
    assign lo = {1'b0, radius_reg} - {16'b0, tol_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg    <= '0;
            radius_reg <= 31'd65536;
            tol_reg    <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CENTER_X:  ctr_reg[0]  <= cfg_data;
                REG_CENTER_Y:  ctr_reg[1]  <= cfg_data;
                REG_CENTER_Z:  ctr_reg[2]  <= cfg_data;
                REG_RADIUS:    radius_reg  <= cfg_data[30:0];
                REG_TOLERANCE: tol_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // squared bounds are registered, updating in the cycle after the config registers change
    always_ff @(posedge aclk) begin
        up_sq_reg  <= 64'(up) * 64'(up);
        lo_sq_reg  <= 62'(lo[30:0]) * 62'(lo[30:0]);
        lo_neg_reg <= lo[31];
        rsq_reg    <= 62'(radius_reg) * 62'(radius_reg);
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage a1: clamp direction, centre relative to origin
    logic     a1_vld_reg;
    ray_ctx_t a1_ctx_reg, a1_ctx_next;

    always_comb begin
        logic signed [31:0] dr;
        logic [2:0][31:0] oi;
        logic [2:0][31:0] di;
        oi[0] = s_data.origin_x;
        oi[1] = s_data.origin_y;
        oi[2] = s_data.origin_z;
        di[0] = s_data.dir_x;
        di[1] = s_data.dir_y;
        di[2] = s_data.dir_z;
        for (int i = 0; i < 3; i++) begin
            dr = $signed(di[i]);
            a1_ctx_next.o[i] = oi[i];
            if (dr > ONE_Q30) begin
                a1_ctx_next.d[i] = ONE_Q30;
            end else if (dr < NEG_ONE_Q30) begin
                a1_ctx_next.d[i] = NEG_ONE_Q30;
            end else begin
                a1_ctx_next.d[i] = dr;
            end
            a1_ctx_next.c[i] = {ctr_reg[i][31], ctr_reg[i]} - {oi[i][31], oi[i]};
        end
    end

    // stage a2: per-axis dot product terms, |c| squares for the surface test
    logic                 a2_vld_reg;
    ray_ctx_t             a2_ctx_reg;
    logic [2:0][34:0]     a2_term_reg, a2_term_next;
    logic [2:0][63:0]     a2_csq_reg, a2_csq_next;
    logic [2:0]           a2_clt_reg, a2_clt_next;

    always_comb begin
        logic [32:0] cabs;
        logic [30:0] dabs;
        logic [63:0] prod;
        logic [34:0] tm;
        for (int i = 0; i < 3; i++) begin
            cabs = a1_ctx_reg.c[i][32] ? 33'(33'd0 - a1_ctx_reg.c[i]) : a1_ctx_reg.c[i];
            dabs = a1_ctx_reg.d[i][31] ? 31'(32'd0 - a1_ctx_reg.d[i]) : a1_ctx_reg.d[i][30:0];
            prod = 64'(cabs) * 64'(dabs);
            tm   = {1'b0, prod[63:30]};
            a2_term_next[i] = (a1_ctx_reg.c[i][32] ^ a1_ctx_reg.d[i][31]) ? 35'(35'd0 - tm) : tm;
            a2_csq_next[i]  = 64'(cabs[31:0]) * 64'(cabs[31:0]);
            a2_clt_next[i]  = cabs < {1'b0, up};
        end
    end

    // stage a3: sums
    logic        a3_vld_reg;
    ray_ctx_t    a3_ctx_reg;
    logic [35:0] a3_tca_reg;
    logic [65:0] a3_csq_reg;
    logic        a3_clt_reg;

    // stage a4: projection foot, surface test
    logic             a4_vld_reg;
    ray_ctx_t         a4_ctx_reg;
    logic [34:0]      a4_tca_reg;
    logic             a4_pos_reg;
    logic             a4_onsurf_reg;
    logic [2:0][34:0] a4_mq_reg, a4_mq_next;

    always_comb begin
        logic [30:0] dabs;
        logic [65:0] prod;
        for (int i = 0; i < 3; i++) begin
            dabs = a3_ctx_reg.d[i][31] ? 31'(32'd0 - a3_ctx_reg.d[i]) : a3_ctx_reg.d[i][30:0];
            prod = 66'(a3_tca_reg[34:0]) * 66'(dabs);
            a4_mq_next[i] = prod[64:30];
        end
    end

    // stage a5: foot-to-centre vector
    logic             a5_vld_reg;
    ray_ctx_t         a5_ctx_reg;
    logic [34:0]      a5_tca_reg;
    logic             a5_live_reg;
    logic             a5_onsurf_reg;
    logic [2:0][30:0] a5_fabs_reg, a5_fabs_next;
    logic             a5_fbig;

    always_comb begin
        logic [36:0] mqs;
        logic [36:0] f;
        logic [36:0] fa;
        a5_fbig = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mqs = a4_ctx_reg.d[i][31] ? 37'(37'd0 - {2'b00, a4_mq_reg[i]})
                                      : {2'b00, a4_mq_reg[i]};
            f   = mqs - {{4{a4_ctx_reg.c[i][32]}}, a4_ctx_reg.c[i]};
            fa  = f[36] ? 37'(37'd0 - f) : f;
            a5_fabs_next[i] = fa[30:0];
            a5_fbig = a5_fbig | (|fa[36:31]);
        end
    end

    // stage a6: squares
    logic             a6_vld_reg;
    ray_ctx_t         a6_ctx_reg;
    logic [34:0]      a6_tca_reg;
    logic             a6_live_reg;
    logic             a6_onsurf_reg;
    logic [2:0][61:0] a6_fsq_reg;

    // stage a7: squared distance
    logic        a7_vld_reg;
    ray_ctx_t    a7_ctx_reg;
    logic [34:0] a7_tca_reg;
    logic        a7_live_reg;
    logic        a7_onsurf_reg;
    logic [63:0] a7_dsq_reg;

    // stage a8: candidate and root radicand
    logic        a8_vld_reg;
    sq_side_t    a8_side_reg;
    logic [63:0] a8_rad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
            a3_vld_reg <= 1'b0;
            a4_vld_reg <= 1'b0;
            a5_vld_reg <= 1'b0;
            a6_vld_reg <= 1'b0;
            a7_vld_reg <= 1'b0;
            a8_vld_reg <= 1'b0;
        end else if (adv) begin
            a1_vld_reg <= s_valid;
            a2_vld_reg <= a1_vld_reg;
            a3_vld_reg <= a2_vld_reg;
            a4_vld_reg <= a3_vld_reg;
            a5_vld_reg <= a4_vld_reg;
            a6_vld_reg <= a5_vld_reg;
            a7_vld_reg <= a6_vld_reg;
            a8_vld_reg <= a7_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_ctx_reg <= a1_ctx_next;

            a2_ctx_reg  <= a1_ctx_reg;
            a2_term_reg <= a2_term_next;
            a2_csq_reg  <= a2_csq_next;
            a2_clt_reg  <= a2_clt_next;

            a3_ctx_reg <= a2_ctx_reg;
            a3_tca_reg <= {a2_term_reg[0][34], a2_term_reg[0]}
                        + {a2_term_reg[1][34], a2_term_reg[1]}
                        + {a2_term_reg[2][34], a2_term_reg[2]};
            a3_csq_reg <= {2'b00, a2_csq_reg[0]} + {2'b00, a2_csq_reg[1]}
                        + {2'b00, a2_csq_reg[2]};
            a3_clt_reg <= &a2_clt_reg;

            a4_ctx_reg    <= a3_ctx_reg;
            a4_tca_reg    <= a3_tca_reg[34:0];
            a4_pos_reg    <= $signed(a3_tca_reg) > $signed({20'b0, tol_reg});
            a4_onsurf_reg <= a3_clt_reg && (a3_csq_reg < {2'b00, up_sq_reg})
                          && (lo_neg_reg || (a3_csq_reg > {4'b0, lo_sq_reg}));
            a4_mq_reg     <= a4_mq_next;

            a5_ctx_reg    <= a4_ctx_reg;
            a5_tca_reg    <= a4_tca_reg;
            a5_live_reg   <= a4_pos_reg && !a5_fbig;
            a5_onsurf_reg <= a4_onsurf_reg;
            a5_fabs_reg   <= a5_fabs_next;

            a6_ctx_reg    <= a5_ctx_reg;
            a6_tca_reg    <= a5_tca_reg;
            a6_live_reg   <= a5_live_reg;
            a6_onsurf_reg <= a5_onsurf_reg;
            for (int i = 0; i < 3; i++) begin
                a6_fsq_reg[i] <= 62'(a5_fabs_reg[i]) * 62'(a5_fabs_reg[i]);
            end

            a7_ctx_reg    <= a6_ctx_reg;
            a7_tca_reg    <= a6_tca_reg;
            a7_live_reg   <= a6_live_reg;
            a7_onsurf_reg <= a6_onsurf_reg;
            a7_dsq_reg    <= 64'(a6_fsq_reg[0]) + 64'(a6_fsq_reg[1]) + 64'(a6_fsq_reg[2]);

            a8_side_reg.ctx    <= a7_ctx_reg;
            a8_side_reg.tca    <= a7_tca_reg;
            a8_side_reg.onsurf <= a7_onsurf_reg;
            a8_side_reg.cand   <= a7_live_reg && (a7_dsq_reg < {2'b00, rsq_reg});
            a8_rad_reg         <= {2'b00, rsq_reg} - a7_dsq_reg;
        end
    end

    // chord half-length
    logic        sq_vld;
    logic [31:0] sq_root;
    sq_side_t    sq_side;

    rsi_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a8_vld_reg),
        .in_rad    (a8_rad_reg),
        .in_side   (a8_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage b1: ray parameter
    logic        b1_vld_reg;
    ray_ctx_t    b1_ctx_reg;
    logic [35:0] b1_tabs_reg;
    logic        b1_tneg_reg;
    logic        b1_ok_reg;
    logic [30:0] b1_dist_reg;
    logic [36:0] b1_t;
    logic [35:0] b1_tabs;

    always_comb begin
        if (sq_side.onsurf) begin
            b1_t = {2'b00, sq_side.tca} + {5'b0, sq_root};
        end else begin
            b1_t = {2'b00, sq_side.tca} - {5'b0, sq_root};
        end
        b1_tabs = b1_t[36] ? 36'(37'd0 - b1_t) : b1_t[35:0];
    end

    // stage b2: t times direction
    logic             b2_vld_reg;
    ray_ctx_t         b2_ctx_reg;
    logic             b2_ok_reg;
    logic [30:0]      b2_dist_reg;
    logic [2:0][36:0] b2_mq_reg, b2_mq_next;
    logic [2:0]       b2_sneg_reg, b2_sneg_next;

    always_comb begin
        logic [30:0] dabs;
        logic [66:0] prod;
        for (int i = 0; i < 3; i++) begin
            dabs = b1_ctx_reg.d[i][31] ? 31'(32'd0 - b1_ctx_reg.d[i]) : b1_ctx_reg.d[i][30:0];
            prod = 67'(b1_tabs_reg) * 67'(dabs);
            b2_mq_next[i]   = prod[66:30];
            b2_sneg_next[i] = b1_tneg_reg ^ b1_ctx_reg.d[i][31];
        end
    end

    // stage b3: hit point, offset from centre, divider setup
    logic             b3_vld_reg;
    dv_side_t         b3_side_reg, b3_side_next;
    logic [2:0][30:0] b3_rem_reg, b3_rem_next;
    logic [2:0][31:0] b3_low_reg, b3_low_next;

    always_comb begin
        logic [37:0] step;
        logic [38:0] p;
        logic [38:0] e;
        logic [37:0] eabs;
        b3_side_next.ok   = b2_ok_reg;
        b3_side_next.tlen = b2_dist_reg;
        for (int i = 0; i < 3; i++) begin
            step = b2_sneg_reg[i] ? 38'(38'd0 - {1'b0, b2_mq_reg[i]}) : {1'b0, b2_mq_reg[i]};
            p    = {{7{b2_ctx_reg.o[i][31]}}, b2_ctx_reg.o[i]} + {step[37], step};
            e    = {step[37], step} - {{6{b2_ctx_reg.c[i][32]}}, b2_ctx_reg.c[i]};
            eabs = e[38] ? 38'(39'd0 - e) : e[37:0];
            if ($signed(p) > $signed({{7{1'b0}}, INT32_MAX})) begin
                b3_side_next.p[i] = INT32_MAX;
            end else if ($signed(p) < $signed({{7{1'b1}}, INT32_MIN})) begin
                b3_side_next.p[i] = INT32_MIN;
            end else begin
                b3_side_next.p[i] = p[31:0];
            end
            b3_side_next.neg[i] = e[38];
            // quotient would need more than 32 bits
            b3_side_next.ovf[i] = eabs[37:2] >= {5'b0, radius_reg};
            b3_rem_next[i]      = eabs[32:2];
            b3_low_next[i]      = {eabs[1:0], 30'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
        end else if (adv) begin
            b1_vld_reg <= sq_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_ctx_reg  <= sq_side.ctx;
            b1_tabs_reg <= b1_tabs;
            b1_tneg_reg <= b1_t[36];
            b1_ok_reg   <= sq_side.cand && !(b1_tabs < {20'b0, tol_reg});
            b1_dist_reg <= (|b1_tabs[35:31]) ? '1 : b1_tabs[30:0];

            b2_ctx_reg  <= b1_ctx_reg;
            b2_ok_reg   <= b1_ok_reg;
            b2_dist_reg <= b1_dist_reg;
            b2_mq_reg   <= b2_mq_next;
            b2_sneg_reg <= b2_sneg_next;

            b3_side_reg <= b3_side_next;
            b3_rem_reg  <= b3_rem_next;
            b3_low_reg  <= b3_low_next;
        end
    end

    // normal = offset * 2^30 / radius
    logic             dv_vld;
    logic [2:0][31:0] dv_quo;
    dv_side_t         dv_side;

    rsi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (b3_vld_reg),
        .den       (radius_reg),
        .in_rem    (b3_rem_reg),
        .in_low    (b3_low_reg),
        .in_side   (b3_side_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // output register
    logic     m_valid_reg;
    hit_out_t m_data_reg, m_data_next;

    always_comb begin
        logic [2:0][31:0] n;
        for (int i = 0; i < 3; i++) begin
            if (dv_side.ovf[i] || dv_quo[i][31]) begin
                n[i] = dv_side.neg[i] ? INT32_MIN : INT32_MAX;
            end else begin
                n[i] = dv_side.neg[i] ? 32'(32'd0 - dv_quo[i]) : dv_quo[i];
            end
        end
        m_data_next = '0;
        if (dv_side.ok) begin
            m_data_next.hit          = 1'b1;
            m_data_next.hit_distance = dv_side.tlen;
            m_data_next.point_x      = dv_side.p[0];
            m_data_next.point_y      = dv_side.p[1];
            m_data_next.point_z      = dv_side.p[2];
            m_data_next.normal_x     = n[0];
            m_data_next.normal_y     = n[1];
            m_data_next.normal_z     = n[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// File: hw/rtl/rsi_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rsi_checker import rsi_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input hit_out_t m_data
);

    // a held result beat keeps its payload
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // a stalled result holds s_ready low, so no input beat is taken
    `ASSERT_IMPLY(a_stall_blocks_in, aclk, aresetn, m_valid && !m_ready, !s_ready)

    // a miss carries only zeros
    `ASSERT_IMPLY(a_miss_zero, aclk, aresetn, m_valid && !m_data.hit,
        m_data.hit_distance == 0 && m_data.point_x == 0 && m_data.point_y == 0 &&
        m_data.point_z == 0 && m_data.normal_x == 0 && m_data.normal_y == 0 &&
        m_data.normal_z == 0)

    // nothing comes out right after reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // an empty output stage never blocks an input beat
    `ASSERT_IMPLY(a_ready_when_free, aclk, aresetn, !m_valid && s_valid, s_ready)

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
